@@ rtl/lst_pkg.sv @@
package lst_pkg;
	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  owner_id;
		logic [15:0] label_id;
		logic [31:0] elapsed_us;
		logic [31:0] threshold_us;
		logic [47:0] now_us;
		logic [5:0]  index;
	} req_t;

	typedef struct packed {
		logic        warning;
		logic [1:0]  status;
		logic [7:0]  entry_owner;
		logic [15:0] entry_label;
		logic [31:0] calls;
		logic [47:0] total_us;
		logic [31:0] max_us;
		logic [31:0] last_us;
		logic [31:0] slow_calls;
		logic [31:0] entry_threshold_us;
		logic [6:0]  removed;
		logic [6:0]  entries;
	} rsp_t;

	localparam logic [1:0] OP_RECORD = 2'd0;
	localparam logic [1:0] OP_READ   = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_OOR  = 2'd2;

	localparam logic [3:0] ADDR_DEF_THR  = 4'd0;
	localparam logic [3:0] ADDR_COOLDOWN = 4'd8;

	localparam int REC_W = 8 + 16 + 32 + 32 + 48 + 32 + 32 + 32 + 48 + 1;
endpackage

@@ rtl/lst_ram.sv @@
module lst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/latency_stats_table_top.sv @@
// Latency statistics table. A request is taken when start is high and busy
// is low; its one result appears for a single cycle with done high and must
// be captured then, since the block cannot be stalled. All entries live in
// one memory with a registered read, so record and remove requests walk the
// table one entry per cycle. A record searches, then does a read-modify-write;
// a read fetches one entry; a remove reads and compacts in one pass; an unused
// op returns only the entry count. Configuration is to be written through the
// APB port only while the block is idle; the block itself does not enforce this.
module latency_stats_table_top #(
	parameter int ENTRIES    = 64,
	parameter int OWNER_BITS = 8,
	parameter int LABEL_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  lst_pkg::req_t req,
	output logic          done,
	output lst_pkg::rsp_t rsp,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [63:0]   pwdata,
	output logic [63:0]   prdata,
	output logic          pready
);
	import lst_pkg::*;

	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_RMW  = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_REM  = 3'd4;
	localparam logic [2:0] S_UPD  = 3'd5;

	typedef struct packed {
		logic [7:0]  owner;
		logic [15:0] label;
		logic [31:0] thr;
		logic [31:0] calls;
		logic [47:0] sum;
		logic [31:0] last;
		logic [31:0] maxd;
		logic [31:0] slow;
		logic [47:0] wtime;
		logic        warned;
	} rec_t;

	logic [31:0] dthr_q;
	logic [47:0] cool_q;
	logic [2:0]  state_q;
	logic [CW-1:0] live_q, w_q, ri_q;
	logic        rv_q;
	logic [AW-1:0] rad_q;
	req_t        r_q;
	logic        fresh_q;
	logic [AW-1:0] pos_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	rec_t          wdata, rdata, cur;

	logic          done_d;
	rsp_t          rsp_d;

	lst_ram #(.WIDTH(REC_W), .DEPTH(ENTRIES)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	logic [OWNER_BITS-1:0] own_m;
	logic [LABEL_BITS-1:0] lab_m;
	logic [7:0]  own_e;
	logic [15:0] lab_e;
	assign own_m = r_q.owner_id[OWNER_BITS-1:0];
	assign lab_m = r_q.label_id[LABEL_BITS-1:0];
	assign own_e = 8'(own_m);
	assign lab_e = 16'(lab_m);

	logic hit;
	assign hit = rdata.owner == own_e && rdata.label == lab_e;

	logic [31:0] thr;
	logic        slow, warn;
	logic [48:0] sum_w;
	logic [47:0] dt;
	assign thr = (r_q.threshold_us != 0) ? r_q.threshold_us : dthr_q;
	always_comb begin
		cur = fresh_q ? '0 : rdata;
		if (fresh_q) begin
			cur.owner = own_e;
			cur.label = lab_e;
		end
		slow = r_q.elapsed_us >= thr;
		dt = r_q.now_us - cur.wtime;
		warn = slow && (!cur.warned || (r_q.now_us >= cur.wtime && dt >= cool_q));
		sum_w = {1'b0, cur.sum} + 49'(r_q.elapsed_us);
		wdata = cur;
		wdata.thr = thr;
		if (cur.calls != 32'hFFFF_FFFF) wdata.calls = cur.calls + 32'd1;
		wdata.sum = sum_w[48] ? 48'hFFFF_FFFF_FFFF : sum_w[47:0];
		wdata.last = r_q.elapsed_us;
		if (r_q.elapsed_us > cur.maxd) wdata.maxd = r_q.elapsed_us;
		if (slow && cur.slow != 32'hFFFF_FFFF) wdata.slow = cur.slow + 32'd1;
		if (warn) begin
			wdata.warned = 1'b1;
			wdata.wtime = r_q.now_us;
		end
		if (state_q == S_REM) wdata = rdata;
	end

	always_comb begin
		we = 1'b0;
		waddr = pos_q;
		raddr = rad_q;
		if (state_q == S_UPD) we = 1'b1;
		if (state_q == S_REM && rv_q && rdata.owner != own_e) begin
			we = 1'b1;
			waddr = w_q[AW-1:0];
		end
	end

	assign busy = state_q != S_IDLE;
	assign pready = 1'b1;
	always_comb begin
		case (paddr[3])
			1'b0: prdata = {32'd0, dthr_q};
			default: prdata = {16'd0, cool_q};
		endcase
	end

	function automatic rsp_t emit(rec_t e);
		rsp_t o;
		o = '0;
		o.entry_owner = e.owner;
		o.entry_label = e.label;
		o.calls = e.calls;
		o.total_us = e.sum;
		o.max_us = e.maxd;
		o.last_us = e.last;
		o.slow_calls = e.slow;
		o.entry_threshold_us = e.thr;
		return o;
	endfunction

	always_comb begin
		done_d = 1'b0;
		rsp_d = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (req.op)
						OP_RECORD, OP_READ, OP_REMOVE: done_d = 1'b0;
						default: begin
							done_d = 1'b1;
							rsp_d.entries = 7'(live_q);
						end
					endcase
				end
			end
			S_SCAN: begin
				if (!(rv_q && hit) && ri_q >= live_q && live_q >= CW'(ENTRIES)) begin
					done_d = 1'b1;
					rsp_d.status = ST_FULL;
					rsp_d.entry_owner = own_e;
					rsp_d.entry_label = lab_e;
					rsp_d.entries = 7'(live_q);
				end
			end
			S_UPD: begin
				done_d = 1'b1;
				rsp_d = emit(wdata);
				rsp_d.warning = warn;
				rsp_d.entries = 7'(live_q);
			end
			S_RD: begin
				if (rv_q) begin
					done_d = 1'b1;
					if (CW'(r_q.index) < live_q && 32'(r_q.index) < ENTRIES) begin
						rsp_d = emit(rdata);
					end else begin
						rsp_d.status = ST_OOR;
					end
					rsp_d.entries = 7'(live_q);
				end
			end
			S_REM: begin
				if (ri_q >= live_q && !rv_q) begin
					done_d = 1'b1;
					rsp_d.entry_owner = own_e;
					rsp_d.removed = 7'(live_q - w_q);
					rsp_d.entries = 7'(w_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dthr_q <= 32'd1000;
			cool_q <= 48'd5000000;
			state_q <= S_IDLE;
			live_q <= '0;
			w_q <= '0;
			ri_q <= '0;
			rv_q <= 1'b0;
			rad_q <= '0;
			r_q <= '0;
			fresh_q <= 1'b0;
			pos_q <= '0;
			done <= 1'b0;
			rsp <= '0;
		end else begin
			done <= done_d;
			rsp <= rsp_d;
			if (psel && penable && pwrite) begin
				if (paddr == ADDR_DEF_THR) dthr_q <= pwdata[31:0];
				else if (paddr == ADDR_COOLDOWN) cool_q <= pwdata[47:0];
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						r_q <= req;
						rad_q <= (req.op == OP_READ) ? AW'(req.index) : '0;
						ri_q <= '0;
						w_q <= '0;
						rv_q <= 1'b0;
						case (req.op)
							OP_RECORD: state_q <= S_SCAN;
							OP_READ: state_q <= S_RD;
							OP_REMOVE: state_q <= S_REM;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_SCAN: begin
					// rv_q marks that rdata holds entry ri_q-1
					if (rv_q && hit) begin
						pos_q <= AW'(ri_q - 1'b1);
						rad_q <= AW'(ri_q - 1'b1);
						fresh_q <= 1'b0;
						rv_q <= 1'b0;
						state_q <= S_RMW;
					end else if (ri_q >= live_q) begin
						rv_q <= 1'b0;
						if (live_q >= CW'(ENTRIES)) begin
							state_q <= S_IDLE;
						end else begin
							pos_q <= AW'(live_q);
							fresh_q <= 1'b1;
							live_q <= live_q + 1'b1;
							state_q <= S_RMW;
						end
					end else begin
						rad_q <= AW'(ri_q + 1'b1);
						ri_q <= ri_q + 1'b1;
						rv_q <= 1'b1;
					end
				end
				S_RMW: begin
					if (rv_q || fresh_q) begin
						state_q <= S_UPD;
					end else begin
						rv_q <= 1'b1;
					end
				end
				S_UPD: begin
					state_q <= S_IDLE;
				end
				S_RD: begin
					if (rv_q) begin
						state_q <= S_IDLE;
					end else begin
						rv_q <= 1'b1;
					end
				end
				S_REM: begin
					if (rv_q && rdata.owner != own_e) w_q <= w_q + 1'b1;
					if (ri_q >= live_q) begin
						if (!rv_q) begin
							live_q <= w_q;
							state_q <= S_IDLE;
						end
						rv_q <= 1'b0;
					end else begin
						rad_q <= AW'(ri_q + 1'b1);
						ri_q <= ri_q + 1'b1;
						rv_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
module tb;
	import lst_pkg::*;

	localparam int DEPTH = 64;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 20000;
	localparam int REQ_W = $bits(req_t);
	localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
	localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	rsp_t rsp;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	latency_stats_table_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	// shadow of the table
	logic [31:0] m_def_thr;
	logic [47:0] m_cooldown;
	int m_live;
	logic [7:0] m_owner [DEPTH];
	logic [15:0] m_label [DEPTH];
	logic [31:0] m_thr [DEPTH];
	logic [31:0] m_calls [DEPTH];
	logic [47:0] m_total [DEPTH];
	logic [31:0] m_last [DEPTH];
	logic [31:0] m_max [DEPTH];
	logic [31:0] m_slow [DEPTH];
	logic [47:0] m_warn_t [DEPTH];
	logic m_warned [DEPTH];

	req_t pending_reqs [$];
	rsp_t expected_rsps [$];
	int n_sent = 0;
	int n_checked = 0;
	int n_fail = 0;
	int n_warn = 0;
	int n_full = 0;
	int n_removed = 0;
	int idle_cycles = 0;
	int gap = 0;

	task automatic queue_req(input req_t q);
		pending_reqs = {pending_reqs, q};
	endtask

	function automatic rsp_t entry_view(int i);
		rsp_t r;
		r = '0;
		r.entry_owner = m_owner[i];
		r.entry_label = m_label[i];
		r.calls = m_calls[i];
		r.total_us = m_total[i];
		r.max_us = m_max[i];
		r.last_us = m_last[i];
		r.slow_calls = m_slow[i];
		r.entry_threshold_us = m_thr[i];
		return r;
	endfunction

	function automatic rsp_t apply_request(req_t q);
		rsp_t r;
		logic [31:0] thr;
		logic [48:0] sum;
		logic warn_hit;
		int pos;
		r = '0;
		warn_hit = 1'b0;
		pos = m_live;
		thr = (q.threshold_us != 0) ? q.threshold_us : m_def_thr;
		for (int i = 0; i < m_live; i++)
			if (pos == m_live && m_owner[i] == q.owner_id && m_label[i] == q.label_id)
				pos = i;
		if (pos == m_live && m_live >= DEPTH) begin
			r.status = ST_FULL;
			r.entry_owner = q.owner_id;
			r.entry_label = q.label_id;
			r.entries = 7'(m_live);
			n_full++;
			return r;
		end
		if (pos == m_live) begin
			m_live++;
			m_owner[pos] = q.owner_id;
			m_label[pos] = q.label_id;
			m_calls[pos] = '0;
			m_total[pos] = '0;
			m_last[pos] = '0;
			m_max[pos] = '0;
			m_slow[pos] = '0;
			m_warn_t[pos] = '0;
			m_warned[pos] = 1'b0;
		end
		m_thr[pos] = thr;
		if (m_calls[pos] != MAX32) m_calls[pos]++;
		sum = {1'b0, m_total[pos]} + 49'(q.elapsed_us);
		m_total[pos] = sum[48] ? MAX48 : sum[47:0];
		m_last[pos] = q.elapsed_us;
		if (q.elapsed_us > m_max[pos]) m_max[pos] = q.elapsed_us;
		if (q.elapsed_us >= thr) begin
			if (m_slow[pos] != MAX32) m_slow[pos]++;
			if (!m_warned[pos] || (q.now_us >= m_warn_t[pos] &&
					q.now_us - m_warn_t[pos] >= m_cooldown)) begin
				m_warned[pos] = 1'b1;
				m_warn_t[pos] = q.now_us;
				warn_hit = 1'b1;
				n_warn++;
			end
		end
		r = entry_view(pos);
		r.warning = warn_hit;
		return r;
	endfunction

	function automatic rsp_t predict_result(req_t q);
		rsp_t r;
		int w;
		int old;
		r = '0;
		case (q.op)
			OP_RECORD: begin
				r = apply_request(q);
			end
			OP_READ: begin
				if (int'(q.index) < m_live) r = entry_view(int'(q.index));
				else r.status = ST_OOR;
			end
			OP_REMOVE: begin
				w = 0;
				old = m_live;
				for (int i = 0; i < old; i++) begin
					if (m_owner[i] != q.owner_id) begin
						if (w != i) begin
							m_owner[w] = m_owner[i];
							m_label[w] = m_label[i];
							m_thr[w] = m_thr[i];
							m_calls[w] = m_calls[i];
							m_total[w] = m_total[i];
							m_last[w] = m_last[i];
							m_max[w] = m_max[i];
							m_slow[w] = m_slow[i];
							m_warn_t[w] = m_warn_t[i];
							m_warned[w] = m_warned[i];
						end
						w++;
					end
				end
				m_live = w;
				r.entry_owner = q.owner_id;
				r.removed = 7'(old - w);
				n_removed += old - w;
			end
			default: ;
		endcase
		r.entries = 7'(m_live);
		return r;
	endfunction

	task automatic check(input string name, input logic [47:0] exp_v, input logic [47:0] got);
		if (got !== exp_v) begin
			$error("%s exp %0h got %0h", name, exp_v, got);
			n_fail++;
		end
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_rsps = {expected_rsps, predict_result(req)};
				n_sent++;
			end
			if (start && busy) begin
			end else if (gap > 0) begin
				start <= 1'b0;
				gap <= gap - 1;
			end else if (pending_reqs.size() > 0 &&
					!(start && !busy && $urandom_range(0, 3) == 0)) begin
				req <= pending_reqs.pop_front();
				start <= 1'b1;
				if ($urandom_range(0, 2) == 0)
					gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) :
						$urandom_range(1, 4);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n) begin
			if (done) begin
				idle_cycles <= 0;
				if (expected_rsps.size() == 0) begin
					$error("unexpected result");
					n_fail++;
				end else begin
					e = expected_rsps.pop_front();
					n_checked++;
					check("warning", 48'(e.warning), 48'(rsp.warning));
					check("status", 48'(e.status), 48'(rsp.status));
					check("entry_owner", 48'(e.entry_owner), 48'(rsp.entry_owner));
					check("entry_label", 48'(e.entry_label), 48'(rsp.entry_label));
					check("calls", 48'(e.calls), 48'(rsp.calls));
					check("total_us", e.total_us, rsp.total_us);
					check("max_us", 48'(e.max_us), 48'(rsp.max_us));
					check("last_us", 48'(e.last_us), 48'(rsp.last_us));
					check("slow_calls", 48'(e.slow_calls), 48'(rsp.slow_calls));
					check("entry_threshold_us", 48'(e.entry_threshold_us),
						48'(rsp.entry_threshold_us));
					check("removed", 48'(e.removed), 48'(rsp.removed));
					check("entries", 48'(e.entries), 48'(rsp.entries));
				end
			end else if (start && !busy) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no progress");
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic reg_write(input logic [3:0] addr, input logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (addr == ADDR_DEF_THR) m_def_thr = val[31:0];
		else m_cooldown = val[47:0];
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || start || busy || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (DEPTH + 10) @(posedge clk);
	endtask

	function automatic req_t make_req(logic [1:0] op, logic [7:0] own, logic [15:0] lab,
			logic [31:0] el, logic [31:0] th, logic [47:0] now, logic [5:0] idx);
		req_t q;
		q.op = op; q.owner_id = own; q.label_id = lab; q.elapsed_us = el;
		q.threshold_us = th; q.now_us = now; q.index = idx;
		return q;
	endfunction

	function automatic logic [31:0] rand_dur();
		case ($urandom_range(0, 5))
			0: return MAX32 - $urandom_range(0, 3);
			1: return $urandom;
			default: return $urandom_range(0, 3000);
		endcase
	endfunction

	task automatic random_phase(int n, int owners, int labels);
		req_t q;
		logic [47:0] clock_us;
		clock_us = 48'({$urandom, $urandom}) & 48'h0000_FFFF_FFFF;
		for (int k = 0; k < n; k++) begin
			q = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
			clock_us = clock_us + $urandom_range(1, 3000000);
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
					q.op = OP_RECORD;
					q.owner_id = 8'($urandom_range(0, owners - 1));
					q.label_id = 16'($urandom_range(0, labels - 1));
					q.elapsed_us = rand_dur();
					q.threshold_us = ($urandom_range(0, 2) == 0) ? 32'd0 :
						32'($urandom_range(1, 2000));
					q.now_us = ($urandom_range(0, 9) == 0) ? MAX48 - $urandom_range(0, 9) :
						(($urandom_range(0, 9) == 0) ? clock_us - 48'd5000000 : clock_us);
				end
				12, 13, 14, 15: q.op = OP_READ;
				16: q.op = OP_UNUSED;
				17: begin
					q.op = OP_REMOVE;
					q.owner_id = 8'($urandom_range(0, owners));
				end
				default: begin
					q.op = OP_RECORD;
					if ($urandom_range(0, 1) == 0) q.owner_id = 8'($urandom_range(0, owners - 1));
				end
			endcase
			queue_req(q);
		end
		drain();
	endtask

	initial begin
		m_def_thr = 32'd1000;
		m_cooldown = 48'd5000000;
		m_live = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty reads, unused op, extremes, full table
		queue_req(make_req(OP_READ, 8'd0, 16'd0, '0, '0, 48'd1, 6'd0));
		queue_req(make_req(OP_UNUSED, 8'hFF, 16'hFFFF, MAX32, MAX32, MAX48, 6'h3F));
		queue_req(make_req(OP_RECORD, 8'hFF, 16'hFFFF, MAX32, 32'd0, 48'd1, 6'h3F));
		queue_req(make_req(OP_RECORD, 8'hFF, 16'hFFFF, MAX32, MAX32, 48'd2, 6'd0));
		queue_req(make_req(OP_RECORD, 8'hFF, 16'hFFFF, MAX32, 32'd1, MAX48, 6'd0));
		queue_req(make_req(OP_RECORD, 8'hFF, 16'hFFFF, 32'd0, 32'd1, 48'd3, 6'd0));
		queue_req(make_req(OP_RECORD, 8'h00, 16'h0000, 32'd999, 32'd0, 48'd1, 6'd0));
		queue_req(make_req(OP_RECORD, 8'h00, 16'h0000, 32'd1000, 32'd0, 48'd5, 6'd0));
		queue_req(make_req(OP_READ, 8'd0, 16'd0, '0, '0, 48'd1, 6'd0));
		queue_req(make_req(OP_READ, 8'd0, 16'd0, '0, '0, 48'd1, 6'd1));
		queue_req(make_req(OP_READ, 8'd0, 16'd0, '0, '0, 48'd1, 6'd2));
		queue_req(make_req(OP_REMOVE, 8'hFF, 16'd0, '0, '0, 48'd1, 6'd0));
		queue_req(make_req(OP_REMOVE, 8'h7E, 16'd0, '0, '0, 48'd1, 6'd0));
		drain();
		// fill to capacity then overflow
		for (int i = 0; i < DEPTH; i++)
			queue_req(make_req(OP_RECORD, 8'(i % 3), 16'(i), 32'(i), 32'd0, 48'(i + 1), 6'd0));
		queue_req(make_req(OP_RECORD, 8'd9, 16'd9, 32'd5, 32'd0, 48'd7, 6'd0));
		queue_req(make_req(OP_RECORD, 8'd1, 16'd1, 32'd5, 32'd0, 48'd7, 6'd0));
		queue_req(make_req(OP_READ, 8'd0, 16'd0, '0, '0, 48'd1, 6'd63));
		queue_req(make_req(OP_REMOVE, 8'd1, 16'd0, '0, '0, 48'd1, 6'd0));
		queue_req(make_req(OP_READ, 8'd0, 16'd0, '0, '0, 48'd1, 6'd42));
		drain();

		random_phase(300, 4, 24);
		reg_write(ADDR_DEF_THR, 64'd1);
		reg_write(ADDR_COOLDOWN, 64'd0);
		random_phase(250, 3, 30);
		reg_write(ADDR_DEF_THR, 64'hFFFF_FFFF);
		reg_write(ADDR_COOLDOWN, 64'hFFFF_FFFF_FFFF);
		random_phase(200, 6, 16);
		reg_write(ADDR_DEF_THR, 64'd1500);
		reg_write(ADDR_COOLDOWN, 64'd2500000);
		random_phase(200, 3, 40);

		$display("%0d requests checked (%0d warnings, %0d table-full refusals,",
			n_checked, n_warn, n_full);
		$display("%0d entries removed)", n_removed);
		if (n_fail == 0 && expected_rsps.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

@@ files.f @@
rtl/lst_pkg.sv
rtl/lst_ram.sv
rtl/latency_stats_table_top.sv
tb/sv/tb.sv
